/* rtl/owbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg: shared definitions for the 1-Wire bus master core
// Widths, command codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int TICK_COUNT_BITS = 10;
  localparam int CFG_W           = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 16;

  typedef logic [TICK_COUNT_BITS-1:0] tick_t;
  typedef logic [CFG_W-1:0]           cfg_val_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam cfg_idx_t CFG_RESET_LOW     = 3'd0;
  localparam cfg_idx_t CFG_PRESENCE_WAIT = 3'd1;
  localparam cfg_idx_t CFG_RESET_RECOV   = 3'd2;
  localparam cfg_idx_t CFG_SLOT          = 3'd3;
  localparam cfg_idx_t CFG_WRITE_ONE_LOW = 3'd4;
  localparam cfg_idx_t CFG_READ_LOW      = 3'd5;

  localparam cfg_val_t RST_RESET_LOW     = 10'd480;
  localparam cfg_val_t RST_PRESENCE_WAIT = 10'd80;
  localparam cfg_val_t RST_RESET_RECOV   = 10'd400;
  localparam cfg_val_t RST_SLOT          = 10'd60;
  localparam cfg_val_t RST_WRITE_ONE_LOW = 10'd1;
  localparam cfg_val_t RST_READ_LOW      = 10'd2;

endpackage

/* rtl/one_wire_bus_master_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_core: 1-Wire bus master, one beat per timing tick
//
// Each input beat is one tick (normally one microsecond). It carries the bus
// level sampled during that tick and an optional command: reset with presence
// detect, write a byte or read a byte, bytes least significant bit first.
// Every accepted input beat yields exactly one output beat with the drive
// level for that tick, busy, a done pulse on the last tick of a command,
// the presence flag of the last reset and the last read byte.
// Commands seen while a command runs (including its done tick) are ignored.
// Pulse lengths come from six 10-bit registers written through the cfg port;
// the user must write them only while no command runs, as the block does not
// enforce it. A register written with zero acts as one. The result of a beat
// is registered in the output register at the clock edge that accepts it.
// Throughput is one beat per cycle while the receiver keeps the output drained.
// The input stays ready while the output register is empty or is being
// drained in the same cycle, so a stalled receiver stalls the input after
// one held result. Synchronous reset clears the sequencer, the flags and the
// output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // line_level [0], command [2:1], write_byte [10:3], zeros above
  input  logic [owbm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // drive_low [0], busy_res [1], done_res [2], presence [3], read_byte [11:4]
  output logic [owbm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  owbm_pkg::cfg_idx_t                  cfg_index,
  input  owbm_pkg::cfg_val_t                  cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_RST_LOW    = 3'd1,
    PH_RST_WAIT   = 3'd2,
    PH_RST_RECOV  = 3'd3,
    PH_SLOT_LOW   = 3'd4,
    PH_SLOT_HIGH  = 3'd5,
    PH_SLOT_RECOV = 3'd6
  } phase_t;

  localparam int CMP_W = ((owbm_pkg::TICK_COUNT_BITS > owbm_pkg::CFG_W) ?
                          owbm_pkg::TICK_COUNT_BITS : owbm_pkg::CFG_W) + 1;

  // Configuration registers.
  owbm_pkg::cfg_val_t reset_low_r, presence_wait_r, reset_recov_r;
  owbm_pkg::cfg_val_t slot_r, write_one_low_r, read_low_r;

  // Sequencer state.
  phase_t           phase_r, phase_nxt;
  owbm_pkg::tick_t  tick_r, tick_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  owbm_pkg::op_t    op_r, op_nxt;
  logic             pres_r, pres_nxt;
  logic [7:0]       rx_r, rx_nxt;

  // Output register.
  logic             out_tvalid_r;
  logic             drive_r, busy_r, done_r;
  logic             drive_nxt, busy_nxt, done_nxt;

  logic             line_level;
  owbm_pkg::op_t    command;
  logic [7:0]       write_byte;
  logic             in_accept;

  assign line_level = in_tdata[0];
  assign command    = owbm_pkg::op_t'(in_tdata[2:1]);
  assign write_byte = in_tdata[10:3];

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(owbm_pkg::OUT_TDATA_W-12){1'b0}}, rx_r, pres_r,
                       done_r, busy_r, drive_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= owbm_pkg::RST_RESET_LOW;
      presence_wait_r <= owbm_pkg::RST_PRESENCE_WAIT;
      reset_recov_r   <= owbm_pkg::RST_RESET_RECOV;
      slot_r          <= owbm_pkg::RST_SLOT;
      write_one_low_r <= owbm_pkg::RST_WRITE_ONE_LOW;
      read_low_r      <= owbm_pkg::RST_READ_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owbm_pkg::CFG_RESET_LOW:     reset_low_r     <= cfg_wdata;
        owbm_pkg::CFG_PRESENCE_WAIT: presence_wait_r <= cfg_wdata;
        owbm_pkg::CFG_RESET_RECOV:   reset_recov_r   <= cfg_wdata;
        owbm_pkg::CFG_SLOT:          slot_r          <= cfg_wdata;
        owbm_pkg::CFG_WRITE_ONE_LOW: write_one_low_r <= cfg_wdata;
        owbm_pkg::CFG_READ_LOW:      read_low_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One tick of the sequencer: command start, sampling, then phase timing.
  always_comb begin
    phase_t             ph;
    owbm_pkg::op_t      op;
    owbm_pkg::tick_t    tk;
    logic [2:0]         bi;
    logic [7:0]         sh;
    owbm_pkg::cfg_val_t len;
    logic               cur_bit;
    logic               last_tick;

    ph = phase_r;
    op = op_r;
    tk = tick_r;
    bi = bit_r;
    sh = shift_r;
    pres_nxt  = pres_r;
    rx_nxt    = rx_r;
    drive_nxt = 1'b0;
    busy_nxt  = 1'b0;
    done_nxt  = 1'b0;
    len       = '0;
    cur_bit   = 1'b0;
    last_tick = 1'b0;

    if (phase_r == PH_IDLE && command != owbm_pkg::OP_NONE) begin
      op = command;
      tk = '0;
      bi = '0;
      if (command == owbm_pkg::OP_RESET) begin
        ph = PH_RST_LOW;
      end else begin
        ph = PH_SLOT_LOW;
        sh = (command == owbm_pkg::OP_WRITE) ? write_byte : 8'd0;
      end
    end

    if (ph != PH_IDLE) begin
      busy_nxt  = 1'b1;
      drive_nxt = (ph == PH_RST_LOW) || (ph == PH_SLOT_LOW);
      if (ph == PH_RST_RECOV && tk == '0) begin
        pres_nxt = !line_level;
      end
      // A read samples the bus on the first released tick of the slot.
      if (ph == PH_SLOT_HIGH && op == owbm_pkg::OP_READ && tk == '0 && line_level) begin
        sh[bi] = 1'b1;
      end
      cur_bit = sh[bi];

      unique case (ph)
        PH_RST_LOW:   len = reset_low_r;
        PH_RST_WAIT:  len = presence_wait_r;
        PH_RST_RECOV: len = reset_recov_r;
        PH_SLOT_LOW: begin
          if (op == owbm_pkg::OP_READ) len = read_low_r;
          else                         len = cur_bit ? write_one_low_r : slot_r;
        end
        PH_SLOT_HIGH: len = slot_r;
        default:      len = owbm_pkg::cfg_val_t'(1);
      endcase

      last_tick = (CMP_W'(tk) + CMP_W'(1)) >= CMP_W'(len);

      if (last_tick) begin
        tk = '0;
        unique case (ph)
          PH_RST_LOW:  ph = PH_RST_WAIT;
          PH_RST_WAIT: ph = PH_RST_RECOV;
          PH_SLOT_LOW: begin
            if (op == owbm_pkg::OP_WRITE && !cur_bit) ph = PH_SLOT_RECOV;
            else                                      ph = PH_SLOT_HIGH;
          end
          PH_SLOT_HIGH, PH_SLOT_RECOV: begin
            if (bi == 3'd7) begin
              done_nxt = 1'b1;
            end else begin
              bi = bi + 3'd1;
              ph = PH_SLOT_LOW;
            end
          end
          default: done_nxt = 1'b1;
        endcase
        if (done_nxt) begin
          if (op == owbm_pkg::OP_READ) rx_nxt = sh;
          ph = PH_IDLE;
          op = owbm_pkg::OP_NONE;
          bi = '0;
        end
      end else begin
        tk = tk + owbm_pkg::tick_t'(1);
      end
    end

    phase_nxt = ph;
    op_nxt    = op;
    tick_nxt  = tk;
    bit_nxt   = bi;
    shift_nxt = sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      op_r         <= owbm_pkg::OP_NONE;
      tick_r       <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      pres_r       <= 1'b0;
      rx_r         <= '0;
      out_tvalid_r <= 1'b0;
      drive_r      <= 1'b0;
      busy_r       <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r <= phase_nxt;
        op_r    <= op_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        pres_r  <= pres_nxt;
        rx_r    <= rx_nxt;
        drive_r <= drive_nxt;
        busy_r  <= busy_nxt;
        done_r  <= done_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // A finished command leaves the sequencer idle.
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && done_nxt |=> phase_r == PH_IDLE)
    else $error("done beat did not return the sequencer to idle");

  // The bus is only pulled low while a command runs.
  a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && drive_r |-> busy_r)
    else $error("bus driven low outside a command");

  // Done only marks a tick of a running command.
  a_done_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && done_r |-> busy_r)
    else $error("done without busy");

  // The result of each beat is valid in the cycle after it is taken.
  a_one_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid_r)
    else $error("accepted beat produced no result");

endmodule
